// ===== design/rmc_pkg.sv =====
// Shared types and constants for the region mean color block.
`default_nettype none

package rmc_pkg;

    localparam int COORD_W   = 12;
    localparam int COLOR_W   = 8;
    localparam int MARGIN_W  = 8;
    localparam int SUM_W     = 32;
    localparam int COUNT_W   = 25;
    localparam int CHAN_N    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    // pixels at or beyond this coordinate never count
    localparam int MAX_DIM   = 4096;
    localparam int DIM_CMP_W = 17;

    // accumulation stops at this count until the next result
    localparam logic [COUNT_W-1:0] COUNT_CAP = 25'd16777216;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 3'd4;

    // one finished region, handed from front to back
    typedef struct packed {
        logic [CHAN_N-1:0][SUM_W-1:0] sum;
        logic [COUNT_W-1:0]           count;
    } t_job;

    // queue head status seen by the back end
    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_head;

endpackage

`default_nettype wire

// ===== design/rmc_front.sv =====
// Front end: config registers, region test and per-channel accumulation.
`default_nettype none

module rmc_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [rmc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rmc_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  wire logic                            i_pix_valid,
    input  wire logic [rmc_pkg::COLOR_W-1:0]     i_pix_red,
    input  wire logic [rmc_pkg::COLOR_W-1:0]     i_pix_green,
    input  wire logic [rmc_pkg::COLOR_W-1:0]     i_pix_blue,
    input  wire logic [rmc_pkg::COORD_W-1:0]     i_pix_row,
    input  wire logic [rmc_pkg::COORD_W-1:0]     i_pix_col,
    input  wire logic                            i_last_pixel,
    input  wire logic                            i_q_full,
    output logic                                 o_pix_stall,
    output logic                                 o_push,
    output rmc_pkg::t_job                        o_job
);

    logic [rmc_pkg::COORD_W-1:0]  r_top, r_bottom, r_left, r_right;
    logic [rmc_pkg::MARGIN_W-1:0] r_margin;
    logic [rmc_pkg::CHAN_N-1:0][rmc_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [rmc_pkg::COUNT_W-1:0]  r_count, n_count;

    logic [rmc_pkg::COORD_W:0] row_lo, row_hi_test, col_lo, col_hi_test;
    logic                      in_dim, row_ok, col_ok, cap_ok, accept, take;
    logic [rmc_pkg::CHAN_N-1:0][rmc_pkg::COLOR_W-1:0] pix;

    assign o_pix_stall = i_q_full;
    assign accept      = i_pix_valid && !o_pix_stall;
    assign pix         = {i_pix_blue, i_pix_green, i_pix_red};

    // lo bound: line + margin; hi bound: coord + margin < line (no signed math)
    assign row_lo      = {1'b0, r_top}  + {5'b0, r_margin};
    assign row_hi_test = {1'b0, i_pix_row} + {5'b0, r_margin};
    assign col_lo      = {1'b0, r_left} + {5'b0, r_margin};
    assign col_hi_test = {1'b0, i_pix_col} + {5'b0, r_margin};

    assign in_dim = (rmc_pkg::DIM_CMP_W'(i_pix_row) < rmc_pkg::DIM_CMP_W'(rmc_pkg::MAX_DIM))
                 && (rmc_pkg::DIM_CMP_W'(i_pix_col) < rmc_pkg::DIM_CMP_W'(rmc_pkg::MAX_DIM));
    assign row_ok = ({1'b0, i_pix_row} >= row_lo) && (row_hi_test < {1'b0, r_bottom});
    assign col_ok = ({1'b0, i_pix_col} >= col_lo) && (col_hi_test < {1'b0, r_right});
    assign cap_ok = r_count < rmc_pkg::COUNT_CAP;
    assign take   = accept && in_dim && row_ok && col_ok && cap_ok;

    always_comb begin
        for (int k = 0; k < rmc_pkg::CHAN_N; k++) begin
            n_sum[k] = r_sum[k] + (take ? rmc_pkg::SUM_W'(pix[k]) : '0);
        end
        n_count = r_count + (take ? rmc_pkg::COUNT_W'(1) : '0);
    end

    assign o_push      = accept && i_last_pixel;
    assign o_job.sum   = n_sum;
    assign o_job.count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= '0;
            r_bottom <= '0;
            r_left   <= '0;
            r_right  <= '0;
            r_margin <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rmc_pkg::CFG_TOP:    r_top    <= i_cfg_data;
                rmc_pkg::CFG_BOTTOM: r_bottom <= i_cfg_data;
                rmc_pkg::CFG_LEFT:   r_left   <= i_cfg_data;
                rmc_pkg::CFG_RIGHT:  r_right  <= i_cfg_data;
                rmc_pkg::CFG_MARGIN: r_margin <= i_cfg_data[rmc_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (o_push) begin
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_sum   <= n_sum;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== design/rmc_queue.sv =====
// Two-entry job queue between front and back.
`default_nettype none

module rmc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire rmc_pkg::t_job     i_job,
    input  wire logic              i_pop,
    output logic                   o_full,
    output rmc_pkg::t_q_head       o_head
);

    rmc_pkg::t_job r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_fill;

    assign o_full       = r_fill == 2'd2;
    assign o_head.valid = r_fill != 2'd0;
    assign o_head.job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            r_fill <= r_fill + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

`default_nettype wire

// ===== design/rmc_back.sv =====
// Back end: rounded mean by restoring division, three lanes, and result register.
`default_nettype none

module rmc_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rmc_pkg::t_q_head              i_head,
    output logic                               o_pop,
    input  wire logic                          i_res_stall,
    output logic                               o_res_valid,
    output logic [rmc_pkg::COLOR_W-1:0]        o_mean_red,
    output logic [rmc_pkg::COLOR_W-1:0]        o_mean_green,
    output logic [rmc_pkg::COLOR_W-1:0]        o_mean_blue,
    output logic [rmc_pkg::COUNT_W-1:0]        o_pixel_total,
    output logic                               o_region_empty
);

    localparam int REM_W = rmc_pkg::SUM_W + 1;
    localparam int BIT_W = $clog2(rmc_pkg::COLOR_W);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } t_back_state;

    t_back_state r_state;
    logic [rmc_pkg::CHAN_N-1:0][REM_W-1:0]           r_rem;
    logic [rmc_pkg::CHAN_N-1:0][rmc_pkg::COLOR_W-1:0] r_quot;
    logic [REM_W-1:0]            r_dshift;
    logic [rmc_pkg::COUNT_W-1:0] r_div;
    logic [BIT_W-1:0]            r_bit;
    logic                        r_empty;

    logic [rmc_pkg::CHAN_N-1:0][REM_W:0] diff;
    logic [REM_W-1:0]                    half;

    assign o_pop = (r_state == ST_IDLE) && i_head.valid;
    assign half  = REM_W'(i_head.job.count >> 1);

    always_comb begin
        for (int k = 0; k < rmc_pkg::CHAN_N; k++) begin
            diff[k] = {1'b0, r_rem[k]} - {1'b0, r_dshift};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_state <= (i_head.job.count == '0) ? ST_OUT : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_bit == '0) r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!i_res_stall) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int k = 0; k < rmc_pkg::CHAN_N; k++) begin
                r_rem[k] <= {1'b0, i_head.job.sum[k]} + half;
            end
            r_quot   <= '0;
            r_div    <= i_head.job.count;
            r_dshift <= REM_W'({i_head.job.count, 7'b0});
            r_bit    <= BIT_W'(rmc_pkg::COLOR_W - 1);
            r_empty  <= i_head.job.count == '0;
        end else if (r_state == ST_DIV) begin
            for (int k = 0; k < rmc_pkg::CHAN_N; k++) begin
                if (!diff[k][REM_W]) begin
                    r_rem[k] <= diff[k][REM_W-1:0];
                end
                r_quot[k] <= {r_quot[k][rmc_pkg::COLOR_W-2:0], !diff[k][REM_W]};
            end
            r_dshift <= r_dshift >> 1;
            r_bit    <= r_bit - BIT_W'(1);
        end
    end

    assign o_res_valid    = r_state == ST_OUT;
    assign o_mean_red     = r_quot[0];
    assign o_mean_green   = r_quot[1];
    assign o_mean_blue    = r_quot[2];
    assign o_pixel_total  = r_div;
    assign o_region_empty = r_empty;

`ifndef SYNTHESIS
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && r_empty |-> r_quot == '0 && r_div == '0)
        else $error("empty region result carries nonzero fields");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_div != '0 && r_dshift != '0)
        else $error("divide running with zero divisor");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV && r_bit == '0 |=> r_state == ST_OUT)
        else $error("divide did not finish after last quotient bit");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state != ST_IDLE)
        else $error("job popped but back end stayed idle");
`endif

endmodule

`default_nettype wire

// ===== design/region_mean_color.sv =====
// Top level of the region mean color block: front, job queue and back.
// Throughput: one pixel beat per cycle; input stalls only while the two-entry job queue is full.
// Sequence (back end idle): the last-pixel beat queues the job and the back end pops it; an empty
//   region then goes straight to the result, others first run 8 restoring-division steps, one quotient bit each.
// A new region may stream in while the previous one divides; a third pending region stalls input.
// Reset (i_rst_n low, synchronous): config, sums, count, queue and divider go to zero/idle.
`default_nettype none

module region_mean_color (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config write port
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rmc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rmc_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    // pixel beats
    input  wire logic                            i_pix_valid,
    output logic                                 o_pix_stall,
    input  wire logic [rmc_pkg::COLOR_W-1:0]     i_pix_red,
    input  wire logic [rmc_pkg::COLOR_W-1:0]     i_pix_green,
    input  wire logic [rmc_pkg::COLOR_W-1:0]     i_pix_blue,
    input  wire logic [rmc_pkg::COORD_W-1:0]     i_pix_row,
    input  wire logic [rmc_pkg::COORD_W-1:0]     i_pix_col,
    input  wire logic                            i_last_pixel,
    // result beats
    output logic                                 o_res_valid,
    input  wire logic                            i_res_stall,
    output logic [rmc_pkg::COLOR_W-1:0]          o_mean_red,
    output logic [rmc_pkg::COLOR_W-1:0]          o_mean_green,
    output logic [rmc_pkg::COLOR_W-1:0]          o_mean_blue,
    output logic [rmc_pkg::COUNT_W-1:0]          o_pixel_total,
    output logic                                 o_region_empty
);

    logic             q_full, push, pop;
    rmc_pkg::t_job    job;
    rmc_pkg::t_q_head head;

    // config registers sit in the front; writes always land
    assign o_cfg_ready = 1'b1;

    // front: region test and accumulation, pushes one job per last-pixel beat
    rmc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pix_valid  (i_pix_valid),
        .i_pix_red    (i_pix_red),
        .i_pix_green  (i_pix_green),
        .i_pix_blue   (i_pix_blue),
        .i_pix_row    (i_pix_row),
        .i_pix_col    (i_pix_col),
        .i_last_pixel (i_last_pixel),
        .i_q_full     (q_full),
        .o_pix_stall  (o_pix_stall),
        .o_push       (push),
        .o_job        (job)
    );

    // decouples accumulation from division
    rmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    // back: rounded means, holds the result until taken
    rmc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .i_res_stall    (i_res_stall),
        .o_res_valid    (o_res_valid),
        .o_mean_red     (o_mean_red),
        .o_mean_green   (o_mean_green),
        .o_mean_blue    (o_mean_blue),
        .o_pixel_total  (o_pixel_total),
        .o_region_empty (o_region_empty)
    );

endmodule

`default_nettype wire

// ===== dv/region_mean_color_test.sv =====
// Self-checking testbench for region_mean_color: directed script, then random region scans.
`timescale 1ns / 1ps

module region_mean_color_test;

    import rmc_pkg::*;

    // Slack after the last beat so the divider can finish a nonempty region.
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 8;
    localparam int BEATS_PER_PHASE = 100;
    // Indexes past the register map; writes there must leave the config untouched.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } t_pixel_beat;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COUNT_W-1:0] total;
        logic               empty;
    } t_mean_result;

    typedef enum logic { ROW_PIXEL, ROW_REG } t_script_kind;

    // One line of the directed script: either a pixel beat or a register write.
    // Pixel rows may carry a hand-typed result that replaces the predicted one.
    typedef struct {
        t_script_kind           kind;
        t_pixel_beat            beat;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DAT_W-1:0]   data;
        logic                   typed;
        t_mean_result           want;
    } t_script_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DAT_W-1:0]   i_cfg_data;
    logic                   i_pix_valid;
    logic                   o_pix_stall;
    logic [COLOR_W-1:0]     i_pix_red;
    logic [COLOR_W-1:0]     i_pix_green;
    logic [COLOR_W-1:0]     i_pix_blue;
    logic [COORD_W-1:0]     i_pix_row;
    logic [COORD_W-1:0]     i_pix_col;
    logic                   i_last_pixel;
    logic                   o_res_valid;
    logic                   i_res_stall;
    logic [COLOR_W-1:0]     o_mean_red;
    logic [COLOR_W-1:0]     o_mean_green;
    logic [COLOR_W-1:0]     o_mean_blue;
    logic [COUNT_W-1:0]     o_pixel_total;
    logic                   o_region_empty;

    region_mean_color i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pix_valid    (i_pix_valid),
        .o_pix_stall    (o_pix_stall),
        .i_pix_red      (i_pix_red),
        .i_pix_green    (i_pix_green),
        .i_pix_blue     (i_pix_blue),
        .i_pix_row      (i_pix_row),
        .i_pix_col      (i_pix_col),
        .i_last_pixel   (i_last_pixel),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_mean_red     (o_mean_red),
        .o_mean_green   (o_mean_green),
        .o_mean_blue    (o_mean_blue),
        .o_pixel_total  (o_pixel_total),
        .o_region_empty (o_region_empty)
    );

    // ------------------------------------------------------------------
    // Predictor state: a shadow of the config registers and accumulators
    // ------------------------------------------------------------------
    logic [COORD_W-1:0]  cell_top, cell_bottom, cell_left, cell_right;
    logic [MARGIN_W-1:0] cell_margin;
    logic [SUM_W-1:0]    acc_red, acc_green, acc_blue;
    logic [COUNT_W-1:0]  acc_count;

    t_mean_result pending_means[$];   // predicted results, oldest first
    t_mean_result oldest_mean;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int beats_sent;
    int scans_sent;
    int results_seen;
    int reg_writes;

    always #5 i_clk = ~i_clk;

    // Bounds are compared as ints so that margin crossing never wraps.
    function automatic logic in_cell(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
        int m;
        int r_lo, r_hi, c_lo, c_hi;
        m    = int'(cell_margin);
        r_lo = int'(cell_top) + m;
        r_hi = int'(cell_bottom) - m;
        c_lo = int'(cell_left) + m;
        c_hi = int'(cell_right) - m;
        if (int'(row) >= MAX_DIM || int'(col) >= MAX_DIM) begin
            return 1'b0;
        end
        return int'(row) >= r_lo && int'(row) < r_hi && int'(col) >= c_lo && int'(col) < c_hi;
    endfunction

    // Round half up: (sum + count/2) / count
    function automatic logic [COLOR_W-1:0] rounded_mean(logic [SUM_W-1:0] sum,
                                                        logic [COUNT_W-1:0] count);
        logic [63:0] q;
        q = (64'(sum) + 64'(count >> 1)) / 64'(count);
        return q[COLOR_W-1:0];
    endfunction

    // Accumulate one accepted beat; on the last pixel hand back the region result.
    task automatic absorb_pixel(input t_pixel_beat px, output logic done,
                                output t_mean_result res);
        if (in_cell(px.row, px.col) && acc_count < COUNT_CAP) begin
            acc_red   += SUM_W'(px.red);
            acc_green += SUM_W'(px.green);
            acc_blue  += SUM_W'(px.blue);
            acc_count += 1'b1;
        end
        done = px.last;
        res  = '0;
        if (px.last) begin
            if (acc_count == 0) begin
                res.empty = 1'b1;
            end else begin
                res.red   = rounded_mean(acc_red, acc_count);
                res.green = rounded_mean(acc_green, acc_count);
                res.blue  = rounded_mean(acc_blue, acc_count);
                res.total = acc_count;
            end
            acc_red   = '0;
            acc_green = '0;
            acc_blue  = '0;
            acc_count = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t: mismatch in %s, got %0d want %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Pixel sender: random idle cycles, then hold the beat until accepted
    // ------------------------------------------------------------------
    task automatic send_pixel(input t_pixel_beat px, input logic typed,
                              input t_mean_result want);
        logic done;
        t_mean_result res;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_pix_valid = 1'b0;
            @(negedge i_clk);
        end
        i_pix_valid  = 1'b1;
        i_pix_red    = px.red;
        i_pix_green  = px.green;
        i_pix_blue   = px.blue;
        i_pix_row    = px.row;
        i_pix_col    = px.col;
        i_last_pixel = px.last;
        @(posedge i_clk);
        while (o_pix_stall) @(posedge i_clk);
        absorb_pixel(px, done, res);
        beats_sent++;
        if (done) begin
            scans_sent++;
            pending_means.push_back(typed ? want : res);
        end
    endtask

    // Drop valid, let every pending result drain, then cover the divider latency.
    task automatic settle_block();
        @(negedge i_clk);
        i_pix_valid = 1'b0;
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        settle_block();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_TOP:    cell_top    = data;
            CFG_BOTTOM: cell_bottom = data;
            CFG_LEFT:   cell_left   = data;
            CFG_RIGHT:  cell_right  = data;
            CFG_MARGIN: cell_margin = data[MARGIN_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic program_cell(input logic [CFG_DAT_W-1:0] top,
                                input logic [CFG_DAT_W-1:0] bottom,
                                input logic [CFG_DAT_W-1:0] left,
                                input logic [CFG_DAT_W-1:0] right,
                                input logic [CFG_DAT_W-1:0] margin_data);
        write_register(CFG_TOP, top);
        write_register(CFG_BOTTOM, bottom);
        write_register(CFG_LEFT, left);
        write_register(CFG_RIGHT, right);
        write_register(CFG_MARGIN, margin_data);
    endtask

    // Small random cell, margin upper data bits random (they get masked),
    // sometimes followed by a write to an unmapped index.
    task automatic random_cell();
        int t, b, l, r;
        t = $urandom_range(4095);
        b = t + $urandom_range(48);
        l = $urandom_range(4095);
        r = l + $urandom_range(48);
        if (b > 4095) b = 4095;
        if (r > 4095) r = 4095;
        program_cell(CFG_DAT_W'(t), CFG_DAT_W'(b), CFG_DAT_W'(l), CFG_DAT_W'(r),
                     {4'($urandom), 8'($urandom_range(8))});
        if ($urandom_range(3) == 0) begin
            write_register(CFG_IDX_W'($urandom_range(CFG_UNUSED_HI, CFG_UNUSED_LO)),
                           CFG_DAT_W'($urandom));
        end
    endtask

    // Coordinate around a cell edge: mostly just inside, a few just outside.
    function automatic logic [COORD_W-1:0] near_coord(int lo, int hi);
        int a, b;
        a = (lo - 2 < 0) ? 0 : lo - 2;
        b = (hi + 1 > 4095) ? 4095 : hi + 1;
        if (a > b) begin
            return COORD_W'($urandom);
        end
        return COORD_W'($urandom_range(b, a));
    endfunction

    function automatic logic [COLOR_W-1:0] color_value();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    function automatic t_script_row pixel_row(int r, int g, int b, int row, int col, logic last);
        t_script_row s;
        s       = '{kind: ROW_PIXEL, default: '0};
        s.beat  = '{COLOR_W'(r), COLOR_W'(g), COLOR_W'(b), COORD_W'(row), COORD_W'(col), last};
        return s;
    endfunction

    // Attach a result that can be read straight off the cell setup.
    function automatic t_script_row known(t_script_row s, int r, int g, int b, int total,
                                          logic empty);
        s.typed = 1'b1;
        s.want  = '{COLOR_W'(r), COLOR_W'(g), COLOR_W'(b), COUNT_W'(total), empty};
        return s;
    endfunction

    function automatic t_script_row reg_row(logic [CFG_IDX_W-1:0] idx, int data);
        t_script_row s;
        s       = '{kind: ROW_REG, default: '0};
        s.index = idx;
        s.data  = CFG_DAT_W'(data);
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall at the falling edge, check at the rising edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_res_stall = ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (pending_means.size() == 0) begin
                report_mismatch("result beat with nothing pending", 1, 0);
            end else begin
                oldest_mean = pending_means.pop_front();
                results_seen++;
                if (o_mean_red !== oldest_mean.red)
                    report_mismatch("mean_red", o_mean_red, oldest_mean.red);
                if (o_mean_green !== oldest_mean.green)
                    report_mismatch("mean_green", o_mean_green, oldest_mean.green);
                if (o_mean_blue !== oldest_mean.blue)
                    report_mismatch("mean_blue", o_mean_blue, oldest_mean.blue);
                if (o_pixel_total !== oldest_mean.total)
                    report_mismatch("pixel_total", o_pixel_total, oldest_mean.total);
                if (o_region_empty !== oldest_mean.empty)
                    report_mismatch("region_empty", o_region_empty, oldest_mean.empty);
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timed out with %0d results still pending", pending_means.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        t_script_row  script[$];
        t_pixel_beat  px;
        t_mean_result none;
        int           scan_len;
        int           phase_beats;
        int           scans;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_pix_valid    = 1'b0;
        i_pix_red      = '0;
        i_pix_green    = '0;
        i_pix_blue     = '0;
        i_pix_row      = '0;
        i_pix_col      = '0;
        i_last_pixel   = 1'b0;
        i_res_stall    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        beats_sent     = 0;
        scans_sent     = 0;
        results_seen   = 0;
        reg_writes     = 0;
        none           = '0;
        cell_top       = '0;
        cell_bottom    = '0;
        cell_left      = '0;
        cell_right     = '0;
        cell_margin    = '0;
        acc_red        = '0;
        acc_green      = '0;
        acc_blue       = '0;
        acc_count      = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // --------------------------------------------------------------
        // Directed script
        // --------------------------------------------------------------
        // Out of reset the cell is all zeros: nothing can fall inside.
        script.push_back(known(pixel_row(255, 255, 255, 0, 0, 1), 0, 0, 0, 0, 1'b1));
        // Whole image, no margin.
        script.push_back(reg_row(CFG_TOP, 0));
        script.push_back(reg_row(CFG_BOTTOM, 4095));
        script.push_back(reg_row(CFG_LEFT, 0));
        script.push_back(reg_row(CFG_RIGHT, 4095));
        script.push_back(reg_row(CFG_MARGIN, 0));
        script.push_back(known(pixel_row(255, 0, 255, 0, 0, 1), 255, 0, 255, 1, 1'b0));
        // Far corner: bottom and right bounds are exclusive.
        script.push_back(pixel_row(255, 255, 255, 4094, 4094, 0));
        script.push_back(pixel_row(0, 0, 0, 4095, 0, 0));
        script.push_back(pixel_row(0, 0, 0, 0, 4095, 0));
        script.push_back(known(pixel_row(1, 2, 3, 4095, 4095, 1), 255, 255, 255, 1, 1'b0));
        // Exact halves round up.
        script.push_back(pixel_row(0, 0, 0, 5, 5, 0));
        script.push_back(known(pixel_row(1, 255, 254, 6, 6, 1), 1, 128, 127, 2, 1'b0));
        // Margin at its maximum; upper data bits are dropped.
        script.push_back(reg_row(CFG_MARGIN, 12'hFFF));
        script.push_back(pixel_row(200, 100, 50, 254, 255, 0));
        script.push_back(pixel_row(10, 20, 30, 255, 255, 0));
        script.push_back(pixel_row(0, 0, 0, 3840, 300, 0));
        script.push_back(pixel_row(7, 7, 7, 3839, 3839, 1));
        // Margins meet: collapsed cell.
        script.push_back(reg_row(CFG_TOP, 10));
        script.push_back(reg_row(CFG_BOTTOM, 20));
        script.push_back(reg_row(CFG_MARGIN, 12'hF05));
        script.push_back(known(pixel_row(9, 9, 9, 15, 15, 1), 0, 0, 0, 0, 1'b1));
        // Top below bottom: inverted cell.
        script.push_back(reg_row(CFG_TOP, 3000));
        script.push_back(reg_row(CFG_BOTTOM, 100));
        script.push_back(reg_row(CFG_MARGIN, 0));
        script.push_back(pixel_row(255, 255, 255, 3000, 50, 0));
        script.push_back(known(pixel_row(1, 1, 1, 100, 100, 1), 0, 0, 0, 0, 1'b1));
        // Unmapped indexes are ignored.
        script.push_back(reg_row(CFG_TOP, 0));
        script.push_back(reg_row(CFG_BOTTOM, 4095));
        script.push_back(reg_row(CFG_UNUSED_LO, 4095));
        script.push_back(reg_row(CFG_UNUSED_HI, 0));
        script.push_back(pixel_row(128, 64, 32, 2048, 2048, 0));
        script.push_back(pixel_row(0, 255, 0, 0, 4094, 0));
        script.push_back(pixel_row(255, 255, 255, 1000, 3000, 1));

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG)
                write_register(script[i].index, script[i].data);
            else
                send_pixel(script[i].beat, script[i].typed, script[i].want);
        end
        settle_block();

        // --------------------------------------------------------------
        // Random scans: four idle/stall mixes, each run in two phases with their own cell setups
        // --------------------------------------------------------------
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            case (phase)
                0: program_cell(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0);
                1: program_cell(12'd0, 12'd4095, 12'd0, 12'd4095, 12'hFFF);
                2: program_cell(CFG_DAT_W'($urandom_range(4095, 2048)),
                                CFG_DAT_W'($urandom_range(2047, 0)),
                                CFG_DAT_W'($urandom_range(4095, 2048)),
                                CFG_DAT_W'($urandom_range(2047, 0)),
                                CFG_DAT_W'($urandom));
                3: program_cell(12'd4095, 12'd4095, 12'd0, 12'd4095, CFG_DAT_W'($urandom));
                default: random_cell();
            endcase

            phase_beats = 0;
            scans       = 0;
            while (phase_beats < BEATS_PER_PHASE) begin
                // a full drain once per phase, then a fresh cell a bit later
                if (scans == 3) settle_block();
                if (scans == 6) random_cell();
                scan_len = ($urandom_range(15) == 0) ? $urandom_range(60, 30)
                                                     : $urandom_range(16, 1);
                for (int k = 0; k < scan_len; k++) begin
                    px.red   = color_value();
                    px.green = color_value();
                    px.blue  = color_value();
                    if ($urandom_range(9) < 7) begin
                        px.row = near_coord(int'(cell_top) + int'(cell_margin),
                                            int'(cell_bottom) - int'(cell_margin));
                        px.col = near_coord(int'(cell_left) + int'(cell_margin),
                                            int'(cell_right) - int'(cell_margin));
                    end else begin
                        px.row = COORD_W'($urandom);
                        px.col = COORD_W'($urandom);
                    end
                    px.last = (k == scan_len - 1);
                    send_pixel(px, 1'b0, none);
                end
                phase_beats += scan_len;
                scans++;
            end
        end

        settle_block();
        $display("Covered %0d pixel beats in %0d region scans, %0d results checked, %0d writes",
                 beats_sent, scans_sent, results_seen, reg_writes);
        $display("Cells: reset, full image, max margin, collapsed, inverted, random; 4 mixes");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rmc_pkg.sv
design/rmc_front.sv
design/rmc_queue.sv
design/rmc_back.sv
design/region_mean_color.sv
dv/region_mean_color_test.sv
